### design/lpq_pkg.sv
// lpq_pkg: sizes, request/response structs, status and request codes,
// memory port bundles and the sequencer state type for the lottery queue.
// Used by lpq_ctrl and the top; depends on nothing.
package lpq_pkg;

   localparam int NUM_PROCS    = 64;
   localparam int NUM_QUEUES   = 8;
   localparam int LINK_ENTRIES = 80;

   localparam int ADDR_W   = $clog2(LINK_ENTRIES);
   localparam int PROC_W   = $clog2(NUM_PROCS);
   localparam int STEP_W   = $clog2(NUM_PROCS + 1);
   localparam int TICK_W   = 16;
   localparam int WIN_W    = 22;
   localparam int SUM_W    = TICK_W + STEP_W;
   localparam int CMP_W    = (SUM_W > WIN_W) ? SUM_W : WIN_W;
   localparam int WIDE_W   = ADDR_W + 6;
   localparam int RES_W    = 6;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_DRAW   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BADID = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [3:0]        queue_id;
      logic [6:0]        proc_id;
      logic [TICK_W-1:0] tickets;
      logic [WIN_W-1:0]  winner;
   } req_item_type;

   typedef struct packed {
      logic [RES_W-1:0] result_proc;
      logic [1:0]       status;
   } rsp_item_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } link_port_type;

   typedef struct packed {
      logic              we;
      logic [PROC_W-1:0] waddr;
      logic [TICK_W-1:0] wdata;
      logic [PROC_W-1:0] raddr;
   } tick_port_type;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECODE = 9'b000000100,
      S_APP_W1 = 9'b000001000,
      S_APP_W2 = 9'b000010000,
      S_HEAD   = 9'b000100000,
      S_WALK   = 9'b001000000,
      S_UNL_RD = 9'b010000000,
      S_UNL_WR = 9'b100000000
   } seq_state_type;

   // link value names a process rather than a sentinel
   function automatic logic is_proc(input logic [ADDR_W-1:0] x);
      return WIDE_W'(x) < WIDE_W'(NUM_PROCS);
   endfunction

endpackage

### design/lpq_ram.sv
// lpq_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module lpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lpq_ctrl.sv
// lpq_ctrl: sequencer for the lottery queue: clearing pass, append, head
// removal and the list walk with its ticket accumulator.
// Depends on lpq_pkg; drives the link and ticket RAM ports.
module lpq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lpq_pkg::req_item_type        req_data,
   input  logic                         slot_free,
   output logic                         done,
   output lpq_pkg::rsp_item_type        result,
   output lpq_pkg::link_port_type       next_port,
   output lpq_pkg::link_port_type       prev_port,
   output lpq_pkg::tick_port_type       tick_port,
   input  logic [lpq_pkg::ADDR_W-1:0]   next_rdata,
   input  logic [lpq_pkg::ADDR_W-1:0]   prev_rdata,
   input  logic [lpq_pkg::TICK_W-1:0]   tick_rdata
);

   lpq_pkg::seq_state_type             state_ff, state_in;
   lpq_pkg::req_item_type              req_ff, req_in;
   lpq_pkg::rsp_item_type              res_ff, res_in;
   logic [lpq_pkg::ADDR_W-1:0]         clr_ff, clr_in;
   logic [lpq_pkg::ADDR_W-1:0]         cur_ff, cur_in;
   logic [lpq_pkg::ADDR_W-1:0]         last_ff, last_in;
   logic [lpq_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [lpq_pkg::STEP_W-1:0]         steps_ff, steps_in;
   logic [lpq_pkg::NUM_PROCS-1:0]      queued_ff, queued_in;

   logic                               fin;
   logic [lpq_pkg::WIDE_W-1:0]         head_w, tail_w, clr_w, off_w;
   logic [lpq_pkg::ADDR_W-1:0]         head_a, tail_a, pid_a;
   logic [lpq_pkg::PROC_W-1:0]         pid_i;
   logic                               q_ok, pid_ok;
   logic                               clr_head, clr_tail;
   logic [lpq_pkg::SUM_W-1:0]          sum_new;

   // sentinel addresses of the queue named by the held request
   always_comb begin
      head_w = lpq_pkg::WIDE_W'(lpq_pkg::NUM_PROCS)
             + lpq_pkg::WIDE_W'({req_ff.queue_id, 1'b0});
      tail_w = head_w + lpq_pkg::WIDE_W'(1);
      head_a = head_w[lpq_pkg::ADDR_W-1:0];
      tail_a = tail_w[lpq_pkg::ADDR_W-1:0];
      q_ok   = (lpq_pkg::WIDE_W'(req_ff.queue_id) < lpq_pkg::WIDE_W'(lpq_pkg::NUM_QUEUES))
             && (tail_w < lpq_pkg::WIDE_W'(lpq_pkg::LINK_ENTRIES));
      pid_a  = lpq_pkg::ADDR_W'(req_ff.proc_id);
      pid_i  = lpq_pkg::PROC_W'(req_ff.proc_id);
      pid_ok = lpq_pkg::WIDE_W'(req_ff.proc_id) < lpq_pkg::WIDE_W'(lpq_pkg::NUM_PROCS);
   end

   // sentinel pattern written by the clearing pass
   always_comb begin
      clr_w    = lpq_pkg::WIDE_W'(clr_ff);
      off_w    = clr_w - lpq_pkg::WIDE_W'(lpq_pkg::NUM_PROCS);
      clr_head = (clr_w >= lpq_pkg::WIDE_W'(lpq_pkg::NUM_PROCS)) && !off_w[0]
               && ((off_w >> 1) < lpq_pkg::WIDE_W'(lpq_pkg::NUM_QUEUES))
               && ((clr_w + lpq_pkg::WIDE_W'(1)) < lpq_pkg::WIDE_W'(lpq_pkg::LINK_ENTRIES));
      clr_tail = (clr_w >= lpq_pkg::WIDE_W'(lpq_pkg::NUM_PROCS)) && off_w[0]
               && ((off_w >> 1) < lpq_pkg::WIDE_W'(lpq_pkg::NUM_QUEUES));
   end

   assign sum_new = sum_ff + lpq_pkg::SUM_W'(tick_rdata);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      res_in    = res_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      steps_in  = steps_ff;
      queued_in = queued_ff;
      fin       = 1'b0;
      done      = 1'b0;
      next_port = '0;
      prev_port = '0;
      tick_port = '0;

      case (state_ff)
         lpq_pkg::S_CLEAR: begin
            next_port.we    = 1'b1;
            next_port.waddr = clr_ff;
            next_port.wdata = clr_head ? clr_ff + lpq_pkg::ADDR_W'(1) : '0;
            prev_port.we    = 1'b1;
            prev_port.waddr = clr_ff;
            prev_port.wdata = clr_tail ? clr_ff - lpq_pkg::ADDR_W'(1) : '0;
            tick_port.we    = lpq_pkg::is_proc(clr_ff);
            tick_port.waddr = lpq_pkg::PROC_W'(clr_ff);
            clr_in          = clr_ff + lpq_pkg::ADDR_W'(1);
            if (clr_ff == lpq_pkg::ADDR_W'(lpq_pkg::LINK_ENTRIES - 1)) begin
               state_in = lpq_pkg::S_IDLE;
            end
         end
         lpq_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = lpq_pkg::S_DECODE;
            end
         end
         lpq_pkg::S_DECODE: begin
            if (req_ff.req_type == lpq_pkg::REQ_APPEND && q_ok && pid_ok
                && !queued_ff[pid_i]) begin
               prev_port.raddr = tail_a;
               state_in        = lpq_pkg::S_APP_W1;
            end else if ((req_ff.req_type == lpq_pkg::REQ_REMOVE
                          || req_ff.req_type == lpq_pkg::REQ_DRAW) && q_ok) begin
               next_port.raddr = head_a;
               state_in        = lpq_pkg::S_HEAD;
            end else begin
               res_in = '{result_proc: '0, status: lpq_pkg::ST_BADID};
               fin    = 1'b1;
            end
         end
         lpq_pkg::S_APP_W1: begin
            last_in         = prev_rdata;
            next_port.we    = 1'b1;
            next_port.waddr = pid_a;
            next_port.wdata = tail_a;
            prev_port.we    = 1'b1;
            prev_port.waddr = pid_a;
            prev_port.wdata = prev_rdata;
            tick_port.we    = 1'b1;
            tick_port.waddr = pid_i;
            tick_port.wdata = req_ff.tickets;
            state_in        = lpq_pkg::S_APP_W2;
         end
         lpq_pkg::S_APP_W2: begin
            next_port.we     = 1'b1;
            next_port.waddr  = last_ff;
            next_port.wdata  = pid_a;
            prev_port.we     = 1'b1;
            prev_port.waddr  = tail_a;
            prev_port.wdata  = pid_a;
            queued_in[pid_i] = 1'b1;
            res_in = '{result_proc: lpq_pkg::RES_W'(req_ff.proc_id), status: lpq_pkg::ST_OK};
            fin    = 1'b1;
         end
         lpq_pkg::S_HEAD: begin
            cur_in = next_rdata;
            if (!lpq_pkg::is_proc(next_rdata)) begin
               res_in = '{result_proc: '0, status: lpq_pkg::ST_EMPTY};
               fin    = 1'b1;
            end else if (req_ff.req_type == lpq_pkg::REQ_REMOVE) begin
               state_in = lpq_pkg::S_UNL_RD;
            end else begin
               next_port.raddr = next_rdata;
               tick_port.raddr = lpq_pkg::PROC_W'(next_rdata);
               sum_in          = '0;
               steps_in        = '0;
               state_in        = lpq_pkg::S_WALK;
            end
         end
         lpq_pkg::S_WALK: begin
            // ticket and successor of cur arrive together; one entry a cycle
            sum_in = sum_new;
            if (lpq_pkg::CMP_W'(sum_new) > lpq_pkg::CMP_W'(req_ff.winner)) begin
               state_in = lpq_pkg::S_UNL_RD;
            end else if (!lpq_pkg::is_proc(next_rdata)
                         || steps_ff >= lpq_pkg::STEP_W'(lpq_pkg::NUM_PROCS)) begin
               res_in = '{result_proc: '0, status: lpq_pkg::ST_RANGE};
               fin    = 1'b1;
            end else begin
               cur_in          = next_rdata;
               steps_in        = steps_ff + lpq_pkg::STEP_W'(1);
               next_port.raddr = next_rdata;
               tick_port.raddr = lpq_pkg::PROC_W'(next_rdata);
            end
         end
         lpq_pkg::S_UNL_RD: begin
            next_port.raddr = cur_ff;
            prev_port.raddr = cur_ff;
            state_in        = lpq_pkg::S_UNL_WR;
         end
         lpq_pkg::S_UNL_WR: begin
            next_port.we    = 1'b1;
            next_port.waddr = prev_rdata;
            next_port.wdata = next_rdata;
            prev_port.we    = 1'b1;
            prev_port.waddr = next_rdata;
            prev_port.wdata = prev_rdata;
            queued_in[lpq_pkg::PROC_W'(cur_ff)] = 1'b0;
            res_in = '{result_proc: lpq_pkg::RES_W'(cur_ff), status: lpq_pkg::ST_OK};
            fin    = 1'b1;
         end
         default: begin
            state_in = lpq_pkg::S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // finishing states hold until the response register is free
      if (fin) begin
         if (slot_free) begin
            done     = 1'b1;
            state_in = lpq_pkg::S_IDLE;
         end else begin
            state_in = state_ff;
            queued_in = queued_ff;
            next_port.we = 1'b0;
            prev_port.we = 1'b0;
            cur_in    = cur_ff;
            sum_in    = sum_ff;
            // read again what fed this cycle so the held state sees the same data
            next_port.raddr = (state_ff == lpq_pkg::S_HEAD) ? head_a : cur_ff;
            prev_port.raddr = cur_ff;
            tick_port.raddr = lpq_pkg::PROC_W'(cur_ff);
         end
      end
   end

   assign req_ready = (state_ff == lpq_pkg::S_IDLE);
   assign result    = res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lpq_pkg::S_CLEAR;
         clr_ff    <= '0;
         queued_ff <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         queued_ff <= queued_in;
      end
      req_ff   <= req_in;
      res_ff   <= res_in;
      cur_ff   <= cur_in;
      last_ff  <= last_in;
      sum_ff   <= sum_in;
      steps_ff <= steps_in;
   end

endmodule

### design/lottery_process_queue_top.sv
// A bad request is answered from decode and an empty queue from the head read; an
// append writes the new entry and then links it before the tail, a head removal
// unlinks the head, and a draw walks from the head until the running ticket sum
// passes the winner and unlinks that entry, or answers out of range at the list end.
// One request is in work at a time; req_ready rises with rsp_valid, and a held
// response stalls the sequencer. After reset a pass clearing every link entry keeps req_ready low.
module lottery_process_queue_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lpq_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lpq_pkg::rsp_item_type rsp_data
);

   lpq_pkg::link_port_type       next_port, prev_port;
   lpq_pkg::tick_port_type       tick_port;
   logic [lpq_pkg::ADDR_W-1:0]   next_rdata, prev_rdata;
   logic [lpq_pkg::TICK_W-1:0]   tick_rdata;
   logic                         done, slot_free;
   lpq_pkg::rsp_item_type        result;
   logic                         rsp_valid_ff, rsp_valid_in;
   lpq_pkg::rsp_item_type        rsp_ff, rsp_in;

   lpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .slot_free  (slot_free),
      .done       (done),
      .result     (result),
      .next_port  (next_port),
      .prev_port  (prev_port),
      .tick_port  (tick_port),
      .next_rdata (next_rdata),
      .prev_rdata (prev_rdata),
      .tick_rdata (tick_rdata)
   );

   lpq_ram #(.WIDTH(lpq_pkg::ADDR_W), .DEPTH(lpq_pkg::LINK_ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_port.we),
      .wr_addr (next_port.waddr),
      .wr_data (next_port.wdata),
      .rd_addr (next_port.raddr),
      .rd_data (next_rdata)
   );

   lpq_ram #(.WIDTH(lpq_pkg::ADDR_W), .DEPTH(lpq_pkg::LINK_ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_port.we),
      .wr_addr (prev_port.waddr),
      .wr_data (prev_port.wdata),
      .rd_addr (prev_port.raddr),
      .rd_data (prev_rdata)
   );

   lpq_ram #(.WIDTH(lpq_pkg::TICK_W), .DEPTH(lpq_pkg::NUM_PROCS)) u_tick_ram (
      .clock   (clock),
      .wr_en   (tick_port.we),
      .wr_addr (tick_port.waddr),
      .wr_data (tick_port.wdata),
      .rd_addr (tick_port.raddr),
      .rd_data (tick_rdata)
   );

   // response register parts the sequencer from the consumer
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_proc_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == lpq_pkg::ST_OK || rsp_data.result_proc == '0))
      else $error("result process not zero on error status");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> slot_free)
      else $error("response overwritten before it was taken");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped or changed while waiting");

endmodule
